@@ rtl/core/sads_pkg.sv @@
`timescale 1ns / 1ps

package sads_pkg;

   // default configuration
   localparam int DEF_MAX_LEN  = 1024;
   localparam int DEF_ALPHABET = 26;

   // fixed field widths
   localparam int SYM_W   = 5;
   localparam int COUNT_W = 20;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CUR,
      ST_WALK,
      ST_Q,
      ST_LQ,
      ST_RED,
      ST_FIN
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_ACCEPT_WORK,
      OP_ACCEPT_SKIP,
      OP_CUR,
      OP_WALK_ADD,
      OP_WALK_HIT,
      OP_Q_LINK,
      OP_Q_CLONE,
      OP_LQ,
      OP_RED_SET,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic sym_ok;
      logic full;
      logic hit;
      logic link_valid;
      logic len_match;
      logic red_match;
      logic rsp_busy;
   } status_type;

endpackage

@@ rtl/core/sads_if.sv @@
`timescale 1ns / 1ps

// symbol channel
interface sads_req_if;
   logic                       valid;
   logic                       ready;
   logic [sads_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink (input valid, input symbol, output ready);
endinterface

// count channel
interface sads_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sads_pkg::COUNT_W-1:0] distinct_count;
   logic                         full_res;

   modport source (output valid, output distinct_count, output full_res, input ready);
   modport sink (input valid, input distinct_count, input full_res, output ready);
endinterface

@@ rtl/core/sads_dp.sv @@
`timescale 1ns / 1ps

module sads_dp #(
   parameter int MAX_LEN  = sads_pkg::DEF_MAX_LEN,
   parameter int ALPHABET = sads_pkg::DEF_ALPHABET
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [sads_pkg::SYM_W-1:0] sym_in,
   input  sads_pkg::cmd_type          cmd,
   output sads_pkg::status_type       status,
   sads_rsp_if.source                 rsp_bus
);

   localparam int NODE_CAP  = 2 * MAX_LEN;
   localparam int NODE_W    = $clog2(NODE_CAP);
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int SYM_IDX_W = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;

   typedef logic [ALPHABET-1:0][NODE_W-1:0] row_type;

   // node tables
   logic [LEN_W-1:0]  len_mem  [NODE_CAP];
   logic [NODE_W:0]   link_mem [NODE_CAP];
   row_type           row_mem  [NODE_CAP];

   // read data registers
   logic [LEN_W-1:0]  len_q_ff;
   logic [NODE_W:0]   link_q_ff;
   row_type           row_rd_ff;
   logic              rd_root_ff;

   // walk registers
   logic [NODE_W-1:0]          p_ff, p_in;
   logic [NODE_W-1:0]          cur_ff, cur_in;
   logic [NODE_W-1:0]          q_ff, q_in;
   logic [NODE_W-1:0]          cl_ff, cl_in;
   logic [SYM_IDX_W-1:0]       sym_ff, sym_in_idx;
   logic [LEN_W-1:0]           lenp_ff, lenp_in;
   logic [LEN_W-1:0]           cur_len_ff, cur_len_in;
   logic [NODE_W-1:0]          link_tgt_ff, link_tgt_in;
   logic [LEN_W-1:0]           link_len_ff, link_len_in;

   // automaton globals
   logic [NODE_W-1:0]            last_ff, last_in;
   logic [NODE_W:0]              count_ff, count_in;
   logic [LEN_W-1:0]             taken_ff, taken_in;
   logic [sads_pkg::COUNT_W-1:0] total_ff, total_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sads_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                         rsp_full_ff, rsp_full_in;

   // memory control
   logic              rd_en;
   logic [NODE_W-1:0] rd_addr;
   logic              len_we, link_we, row_we;
   logic [NODE_W-1:0] len_wa, link_wa, row_wa;
   logic [LEN_W-1:0]  len_wd;
   logic [NODE_W:0]   link_wd;
   row_type           row_wd;

   // root reads as length zero with no link
   logic [LEN_W-1:0]  len_rd;
   logic              link_rd_valid;
   logic [NODE_W-1:0] link_rd;
   logic [NODE_W-1:0] tr_rd;

   assign len_rd        = rd_root_ff ? '0 : len_q_ff;
   assign link_rd_valid = rd_root_ff ? 1'b0 : link_q_ff[NODE_W];
   assign link_rd       = link_q_ff[NODE_W-1:0];
   assign sym_in_idx    = SYM_IDX_W'(sym_in);
   assign tr_rd         = row_rd_ff[sym_ff];

   // status to the controller
   always_comb begin
      status.sym_ok     = (int'(sym_in) < ALPHABET);
      status.full       = (taken_ff >= LEN_W'(MAX_LEN));
      status.hit        = (tr_rd != '0);
      status.link_valid = link_rd_valid;
      status.len_match  = (len_rd == lenp_ff + LEN_W'(1));
      status.red_match  = (tr_rd == q_ff);
      status.rsp_busy   = rsp_valid_ff && !rsp_bus.ready;
   end

   // operation decode
   always_comb begin
      p_in         = p_ff;
      cur_in       = cur_ff;
      q_in         = q_ff;
      cl_in        = cl_ff;
      lenp_in      = lenp_ff;
      cur_len_in   = cur_len_ff;
      link_tgt_in  = link_tgt_ff;
      link_len_in  = link_len_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      taken_in     = taken_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_full_in  = rsp_full_ff;
      rd_en        = 1'b0;
      rd_addr      = p_ff;
      len_we       = 1'b0;
      len_wa       = cur_ff;
      len_wd       = cur_len_ff;
      link_we      = 1'b0;
      link_wa      = cur_ff;
      link_wd      = {1'b1, link_tgt_ff};
      row_we       = 1'b0;
      row_wa       = p_ff;
      row_wd       = row_rd_ff;
      unique case (cmd.op)
         sads_pkg::OP_INIT: begin
            row_we = 1'b1;
            row_wa = '0;
            row_wd = '0;
         end
         sads_pkg::OP_ACCEPT_WORK: begin
            p_in     = last_ff;
            cur_in   = count_ff[NODE_W-1:0];
            count_in = count_ff + (NODE_W+1)'(1);
            rd_en    = 1'b1;
            rd_addr  = last_ff;
         end
         sads_pkg::OP_ACCEPT_SKIP: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = total_ff;
            rsp_full_in  = status.sym_ok;
         end
         sads_pkg::OP_CUR: begin
            cur_len_in = len_rd + LEN_W'(1);
            len_we     = 1'b1;
            len_wa     = cur_ff;
            len_wd     = len_rd + LEN_W'(1);
            row_we     = 1'b1;
            row_wa     = cur_ff;
            row_wd     = '0;
         end
         sads_pkg::OP_WALK_ADD: begin
            row_we         = 1'b1;
            row_wa         = p_ff;
            row_wd[sym_ff] = cur_ff;
            if (link_rd_valid) begin
               p_in    = link_rd;
               rd_en   = 1'b1;
               rd_addr = link_rd;
            end else begin
               link_tgt_in = '0;
               link_len_in = '0;
            end
         end
         sads_pkg::OP_WALK_HIT: begin
            q_in    = tr_rd;
            lenp_in = len_rd;
            rd_en   = 1'b1;
            rd_addr = tr_rd;
         end
         sads_pkg::OP_Q_LINK: begin
            link_tgt_in = q_ff;
            link_len_in = len_rd;
         end
         sads_pkg::OP_Q_CLONE: begin
            cl_in       = count_ff[NODE_W-1:0];
            count_in    = count_ff + (NODE_W+1)'(1);
            link_tgt_in = count_ff[NODE_W-1:0];
            link_len_in = lenp_ff + LEN_W'(1);
            len_we      = 1'b1;
            len_wa      = count_ff[NODE_W-1:0];
            len_wd      = lenp_ff + LEN_W'(1);
            link_we     = 1'b1;
            link_wa     = count_ff[NODE_W-1:0];
            link_wd     = {link_rd_valid, link_rd};
            row_we      = 1'b1;
            row_wa      = count_ff[NODE_W-1:0];
            row_wd      = row_rd_ff;
         end
         sads_pkg::OP_LQ: begin
            link_we = 1'b1;
            link_wa = q_ff;
            link_wd = {1'b1, cl_ff};
            rd_en   = 1'b1;
            rd_addr = p_ff;
         end
         sads_pkg::OP_RED_SET: begin
            row_we         = 1'b1;
            row_wa         = p_ff;
            row_wd[sym_ff] = cl_ff;
            if (link_rd_valid) begin
               p_in    = link_rd;
               rd_en   = 1'b1;
               rd_addr = link_rd;
            end
         end
         sads_pkg::OP_FIN: begin
            link_we      = 1'b1;
            link_wa      = cur_ff;
            link_wd      = {1'b1, link_tgt_ff};
            last_in      = cur_ff;
            taken_in     = taken_ff + LEN_W'(1);
            total_in     = total_ff + sads_pkg::COUNT_W'(cur_len_ff - link_len_ff);
            rsp_valid_in = 1'b1;
            rsp_count_in = total_in;
            rsp_full_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // node tables
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      if (rd_en) begin
         len_q_ff   <= len_mem[rd_addr];
         link_q_ff  <= link_mem[rd_addr];
         row_rd_ff  <= row_mem[rd_addr];
         rd_root_ff <= (rd_addr == '0);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      cur_ff       <= cur_in;
      q_ff         <= q_in;
      cl_ff        <= cl_in;
      lenp_ff      <= lenp_in;
      cur_len_ff   <= cur_len_in;
      link_tgt_ff  <= link_tgt_in;
      link_len_ff  <= link_len_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
      if (cmd.op == sads_pkg::OP_ACCEPT_WORK) begin
         sym_ff <= sym_in_idx;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         count_ff     <= (NODE_W+1)'(1);
         taken_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         count_ff     <= count_in;
         taken_ff     <= taken_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.distinct_count = rsp_count_ff;
   assign rsp_bus.full_res       = rsp_full_ff;

endmodule

@@ rtl/core/sads_ctrl.sv @@
`timescale 1ns / 1ps

module sads_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sads_pkg::status_type status,
   output sads_pkg::cmd_type    cmd
);

   sads_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sads_pkg::ST_INIT: state_in = sads_pkg::ST_IDLE;
         sads_pkg::ST_IDLE: begin
            if (req_valid && !status.rsp_busy && status.sym_ok && !status.full) begin
               state_in = sads_pkg::ST_CUR;
            end
         end
         sads_pkg::ST_CUR: state_in = sads_pkg::ST_WALK;
         sads_pkg::ST_WALK: begin
            if (status.hit) begin
               state_in = sads_pkg::ST_Q;
            end else if (!status.link_valid) begin
               state_in = sads_pkg::ST_FIN;
            end
         end
         sads_pkg::ST_Q: begin
            state_in = status.len_match ? sads_pkg::ST_FIN : sads_pkg::ST_LQ;
         end
         sads_pkg::ST_LQ: state_in = sads_pkg::ST_RED;
         sads_pkg::ST_RED: begin
            if (!status.red_match || !status.link_valid) begin
               state_in = sads_pkg::ST_FIN;
            end
         end
         sads_pkg::ST_FIN: state_in = sads_pkg::ST_IDLE;
         default: state_in = sads_pkg::ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = sads_pkg::OP_NONE;
      unique case (state_ff)
         sads_pkg::ST_INIT: cmd.op = sads_pkg::OP_INIT;
         sads_pkg::ST_IDLE: begin
            req_ready = !status.rsp_busy;
            if (req_valid && !status.rsp_busy) begin
               cmd.op = (status.sym_ok && !status.full) ?
                        sads_pkg::OP_ACCEPT_WORK : sads_pkg::OP_ACCEPT_SKIP;
            end
         end
         sads_pkg::ST_CUR: cmd.op = sads_pkg::OP_CUR;
         sads_pkg::ST_WALK: begin
            cmd.op = status.hit ? sads_pkg::OP_WALK_HIT : sads_pkg::OP_WALK_ADD;
         end
         sads_pkg::ST_Q: begin
            cmd.op = status.len_match ? sads_pkg::OP_Q_LINK : sads_pkg::OP_Q_CLONE;
         end
         sads_pkg::ST_LQ: cmd.op = sads_pkg::OP_LQ;
         sads_pkg::ST_RED: begin
            cmd.op = status.red_match ? sads_pkg::OP_RED_SET : sads_pkg::OP_NONE;
         end
         sads_pkg::ST_FIN: cmd.op = sads_pkg::OP_FIN;
         default: cmd.op = sads_pkg::OP_NONE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sads_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/suffix_automaton_distinct_substrings_core.sv @@
`timescale 1ns / 1ps

// Online suffix automaton: each symbol beat extends the automaton and returns the running
// count of distinct non-empty substrings. Node lengths, links and transition rows sit in
// single-port-read memories with registered read data; a transition row is one wide word,
// so allocating or cloning a node costs one write. An accepted letter passes through the
// accept, node-create, link-walk and finish steps, with a walk step for each suffix link
// followed while adding transitions. Landing on an existing transition adds a length check;
// a clone then adds the clone and link-update steps plus a redirect step per redirected
// transition, and one more step when the redirect walk stops on a different target.
// Out-of-alphabet symbols and symbols after capacity are answered with the current count and
// leave the state alone. A waiting result holds off the next symbol beat. After reset the
// root row is cleared before the first beat.
module suffix_automaton_distinct_substrings_core #(
   parameter int MAX_LEN  = sads_pkg::DEF_MAX_LEN,
   parameter int ALPHABET = sads_pkg::DEF_ALPHABET
) (
   input  logic       clock,
   input  logic       reset,
   sads_req_if.sink   req_bus,
   sads_rsp_if.source rsp_bus
);

   sads_pkg::cmd_type    cmd;
   sads_pkg::status_type status;
   logic                 ready;

   // sequencer
   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = ready;

   // tables and registers
   sads_dp #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .sym_in  (req_bus.symbol),
      .cmd     (cmd),
      .status  (status),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ test/sads_tb_if.sv @@
`timescale 1ns / 1ps

// the block's interfaces are reused as they are; this file carries the scoreboard class
package sads_tb_pkg;

   class count_scoreboard;
      bit [sads_pkg::COUNT_W-1:0] exp_count[$];
      bit                         exp_full[$];
      int                         mismatches;
      int                         max_len;
      int                         alphabet;
      // automaton copy
      int unsigned      len_tab[];
      int unsigned      link_tab[];
      bit               link_ok[];
      int unsigned      trans[][];
      int unsigned      last_n;
      int unsigned      n_nodes;
      int unsigned      taken;
      longint unsigned  total;

      function new(int max_len_p, int alphabet_p);
         max_len  = max_len_p;
         alphabet = alphabet_p;
         len_tab  = new[2 * max_len + 2];
         link_tab = new[2 * max_len + 2];
         link_ok  = new[2 * max_len + 2];
         trans    = new[2 * max_len + 2];
         foreach (trans[i]) trans[i] = new[alphabet];
         last_n = 0;
         n_nodes = 1;
         taken = 0;
         total = 0;
         mismatches = 0;
      endfunction

      function int unsigned make_node(int unsigned l);
         int unsigned n;
         n = n_nodes;
         n_nodes++;
         for (int k = 0; k < alphabet; k++) trans[n][k] = 0;
         len_tab[n] = l;
         link_tab[n] = 0;
         link_ok[n] = 0;
         return n;
      endfunction

      function void grow(int unsigned c);
         int unsigned p, cur, q, cl;
         bit          have;
         p = last_n;
         have = 1;
         cur = make_node(len_tab[p] + 1);
         // walk links adding edges to the new node
         while (have && trans[p][c] == 0) begin
            trans[p][c] = cur;
            if (link_ok[p]) p = link_tab[p];
            else have = 0;
         end
         if (!have) begin
            link_tab[cur] = 0;
            link_ok[cur] = 1;
         end else begin
            q = trans[p][c];
            if (len_tab[q] == len_tab[p] + 1) begin
               link_tab[cur] = q;
               link_ok[cur] = 1;
            end else begin
               // clone q and redirect
               cl = make_node(len_tab[p] + 1);
               trans[cl] = trans[q];
               link_tab[cl] = link_tab[q];
               link_ok[cl] = link_ok[q];
               link_tab[q] = cl;
               link_ok[q] = 1;
               link_tab[cur] = cl;
               link_ok[cur] = 1;
               while (have && trans[p][c] == q) begin
                  trans[p][c] = cl;
                  if (link_ok[p]) p = link_tab[p];
                  else have = 0;
               end
            end
         end
         last_n = cur;
         total += len_tab[cur] - len_tab[link_tab[cur]];
      endfunction

      // accepted symbol beat
      function void note_symbol(bit [sads_pkg::SYM_W-1:0] sym);
         bit full;
         full = 0;
         if (sym >= alphabet) full = 0;
         else if (taken >= max_len) full = 1;
         else begin
            grow(sym);
            taken++;
         end
         exp_count.push_back(total[sads_pkg::COUNT_W-1:0]);
         exp_full.push_back(full);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      // accepted count beat
      task check_count(bit [sads_pkg::COUNT_W-1:0] cnt, bit full);
         bit [sads_pkg::COUNT_W-1:0] ec;
         bit                         ef;
         if (exp_count.size() == 0) begin
            report($sformatf("unexpected beat count=%0d", cnt));
            return;
         end
         ec = exp_count.pop_front();
         ef = exp_full.pop_front();
         if (cnt !== ec) report($sformatf("distinct_count %0d exp %0d", cnt, ec));
         if (full !== ef) report($sformatf("full_res %0b exp %0b", full, ef));
      endtask
   endclass
endpackage

@@ test/suffix_automaton_distinct_substrings_core_tb.sv @@
`timescale 1ns / 1ps

module suffix_automaton_distinct_substrings_core_tb;

   localparam int WATCH_LIMIT = 20000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   stall_cycles;

   sads_req_if req_bus ();
   sads_rsp_if rsp_bus ();

   sads_tb_pkg::count_scoreboard board;

   suffix_automaton_distinct_substrings_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver side and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_count(rsp_bus.distinct_count, rsp_bus.full_res);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCH_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one symbol beat, with optional idle cycles first
   task automatic send_symbol(bit [sads_pkg::SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      do @(posedge clock); while (!req_bus.ready);
      board.note_symbol(sym);
   endtask

   // random words: short repeats make clones likely
   task automatic send_random(int count);
      bit [sads_pkg::SYM_W-1:0] sym;
      int                       span;
      for (int i = 0; i < count; i++) begin
         span = $urandom_range(3) == 0 ? 26 : $urandom_range(2, 4);
         if ($urandom_range(19) == 0) sym = sads_pkg::SYM_W'($urandom_range(26, 31));
         else sym = sads_pkg::SYM_W'($urandom_range(span - 1));
         send_symbol(sym);
      end
   endtask

   initial begin
      board = new(sads_pkg::DEF_MAX_LEN, sads_pkg::DEF_ALPHABET);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_bus.valid = 1'b0;
      req_bus.symbol = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, invalid codes, repeats that force clones
      send_symbol(5'd31);
      send_symbol(5'd0);
      send_symbol(5'd25);
      send_symbol(5'd26);
      send_symbol(5'd0);
      send_symbol(5'd0);
      send_symbol(5'd25);
      send_symbol(5'd0);
      for (int i = 0; i < 10; i++) send_symbol(i % 3 == 2 ? 5'd1 : 5'd0);
      send_symbol(5'd16);
      send_symbol(5'd15);

      // random phases with varied idling
      send_random(120);
      send_idle_pct = 80;
      send_random(120);
      send_idle_pct = 0;
      recv_stall_pct = 80;
      send_random(120);
      send_idle_pct = 13;
      recv_stall_pct = 13;
      send_random(120);
      req_bus.valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (board.exp_count.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/sads_pkg.sv
rtl/core/sads_if.sv
rtl/core/sads_dp.sv
rtl/core/sads_ctrl.sv
rtl/core/suffix_automaton_distinct_substrings_core.sv
test/sads_tb_if.sv
test/suffix_automaton_distinct_substrings_core_tb.sv
